// ----- hw/rtl/wsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfr_pkg
// types and constants shared by the websocket frame receiver
// ----------------------------------------------------------------------------
package wsfr_pkg;

   localparam int BURST_MAX = 6;
   localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);

   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
   localparam logic [3:0] OPC_DATA_MAX = 4'd2;
   localparam logic [3:0] OPC_PING = 4'd9;
   localparam logic [3:0] OPC_PONG = 4'd10;
   localparam logic [15:0] PING_LEN_MAX = 16'd125;
   localparam logic [15:0] RX_CAP_RESET = 16'd5120;
   localparam logic [15:0] MSG_CAP_RESET = 16'd0;

   localparam logic CSR_RX_CAPACITY = 1'b0;
   localparam logic CSR_MSG_CAPACITY = 1'b1;

   typedef enum logic [2:0] {
      PH_HDR1,
      PH_HDR2,
      PH_EXT,
      PH_PAY,
      PH_ERR
   } wsfr_phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_PONG  = 2'd1,
      KIND_EMPTY = 2'd2,
      KIND_ERROR = 2'd3
   } wsfr_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_LEN_CODE  = 2'd1,
      ERR_TOO_LARGE = 2'd2,
      ERR_PING_LONG = 2'd3
   } wsfr_err_type;

   typedef struct packed {
      wsfr_kind_type kind;
      logic          stored;
      logic [15:0]   message_offset;
      logic [3:0]    frame_opcode;
      logic          frame_end;
      logic [15:0]   frame_length;
      logic          message_end;
      logic [15:0]   message_length;
      wsfr_err_type  error_code;
   } wsfr_rsp_type;

endpackage

// ----- hw/rtl/websocket_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// parses websocket frame headers from a byte stream, passes data payload,
// answers short pings with a masked pong and flags fatal framing errors
// ----------------------------------------------------------------------------
// timing: first result registered, valid in the cycle after the byte is accepted
// throughput: one byte per cycle while rsp_tready is high; a byte giving
//   n results holds intake until its last is taken, set by the single-entry
//   result burst buffer (n is 6 at most, on a non-empty ping's last header byte)
// reset: synchronous, returns to header wait and clears the sticky error
// ----------------------------------------------------------------------------
module websocket_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // rx_byte[7:0], pong_mask[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // data_byte[7:0], stored[8], message_offset[24:9], frame_opcode[28:25],
   // frame_end[29], frame_length[45:30], message_end[46],
   // message_length[62:47], error_code[64:63], zero fill
   output logic [71:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // result_kind[1:0]
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   wsfr_pkg::wsfr_phase_type phase_ff, phase_in;
   logic [7:0]  first_ff, first_in;
   logic        ext_ff, ext_in;
   logic [15:0] pay_len_ff, pay_len_in;
   logic [15:0] pay_cnt_ff, pay_cnt_in;
   logic [15:0] msg_cnt_ff, msg_cnt_in;
   logic [31:0] mask_ff, mask_in;
   logic [15:0] rx_cap_ff, msg_cap_ff;

   logic [wsfr_pkg::BURST_CNT_W-1:0] cnt_ff, cnt_in;
   wsfr_pkg::wsfr_rsp_type tmpl_ff, tmpl_in;
   logic [7:0] bytes_ff [wsfr_pkg::BURST_MAX];
   logic [7:0] bytes_in [wsfr_pkg::BURST_MAX];

   logic        accept, pop;
   logic [7:0]  rx_byte;
   logic [31:0] rx_mask;
   logic [3:0]  opc;
   logic        fin;
   logic [6:0]  len_code;
   logic [15:0] len_sel;
   logic        lc_err, hdr_final, too_big, ping_long, fin_err2, fin_err3, hdr_ok;
   logic [15:0] cnt1;
   logic        pay_done;
   logic [15:0] mc_next;
   logic [7:0]  key_byte;

   assign rx_byte  = req_tdata[7:0];
   assign rx_mask  = req_tdata[39:8];
   assign opc      = first_ff[3:0];
   assign fin      = first_ff[7];
   assign len_code = rx_byte[6:0];

   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != '0);
   assign req_tready = (cnt_ff == '0) ||
                       ((cnt_ff == wsfr_pkg::BURST_CNT_W'(1)) && rsp_tready);

   assign len_sel = (phase_ff == wsfr_pkg::PH_EXT) ? {pay_len_ff[7:0], rx_byte}
                                                   : {9'd0, len_code};
   assign lc_err    = (phase_ff == wsfr_pkg::PH_HDR2) &&
                      (len_code == wsfr_pkg::LEN_CODE_EXT64);
   assign hdr_final = ((phase_ff == wsfr_pkg::PH_HDR2) &&
                       (len_code != wsfr_pkg::LEN_CODE_EXT64) &&
                       (len_code != wsfr_pkg::LEN_CODE_EXT16)) ||
                      ((phase_ff == wsfr_pkg::PH_EXT) && ext_ff);
   assign too_big   = (len_sel > rx_cap_ff);
   assign ping_long = (opc == wsfr_pkg::OPC_PING) && (len_sel > wsfr_pkg::PING_LEN_MAX);
   assign fin_err2  = hdr_final && too_big;
   assign fin_err3  = hdr_final && !too_big && ping_long;
   assign hdr_ok    = hdr_final && !too_big && !ping_long;

   assign cnt1     = pay_cnt_ff + 16'd1;
   assign pay_done = (cnt1 >= pay_len_ff);

   always_comb begin
      case (pay_cnt_ff[1:0])
         2'd0:    key_byte = mask_ff[31:24];
         2'd1:    key_byte = mask_ff[23:16];
         2'd2:    key_byte = mask_ff[15:8];
         default: key_byte = mask_ff[7:0];
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         wsfr_pkg::PH_HDR1: phase_in = wsfr_pkg::PH_HDR2;
         wsfr_pkg::PH_HDR2,
         wsfr_pkg::PH_EXT: begin
            if (lc_err || fin_err2 || fin_err3) begin
               phase_in = wsfr_pkg::PH_ERR;
            end else if (hdr_ok) begin
               phase_in = (len_sel == 16'd0) ? wsfr_pkg::PH_HDR1 : wsfr_pkg::PH_PAY;
            end else begin
               phase_in = wsfr_pkg::PH_EXT;
            end
         end
         wsfr_pkg::PH_PAY: phase_in = pay_done ? wsfr_pkg::PH_HDR1 : wsfr_pkg::PH_PAY;
         wsfr_pkg::PH_ERR: phase_in = wsfr_pkg::PH_ERR;
         default:          phase_in = wsfr_pkg::PH_ERR;
      endcase
   end

   // datapath and result burst
   always_comb begin
      first_in   = first_ff;
      ext_in     = ext_ff;
      pay_len_in = pay_len_ff;
      pay_cnt_in = pay_cnt_ff;
      msg_cnt_in = msg_cnt_ff;
      mask_in    = mask_ff;
      mc_next    = msg_cnt_ff;
      cnt_in     = '0;
      tmpl_in    = '0;
      tmpl_in.frame_opcode = opc;
      for (int i = 0; i < wsfr_pkg::BURST_MAX; i++) begin
         bytes_in[i] = 8'd0;
      end

      case (phase_ff)
         wsfr_pkg::PH_HDR1: first_in = rx_byte;
         wsfr_pkg::PH_HDR2: begin
            if (len_code == wsfr_pkg::LEN_CODE_EXT16) begin
               ext_in     = 1'b0;
               pay_len_in = 16'd0;
            end else if (!lc_err) begin
               pay_len_in = len_sel;
            end
         end
         wsfr_pkg::PH_EXT: begin
            pay_len_in = len_sel;
            ext_in     = !ext_ff;
         end
         wsfr_pkg::PH_PAY: begin
            pay_cnt_in = cnt1;
            if (opc <= wsfr_pkg::OPC_DATA_MAX) begin
               cnt_in       = wsfr_pkg::BURST_CNT_W'(1);
               tmpl_in.kind = wsfr_pkg::KIND_DATA;
               bytes_in[0]  = rx_byte;
               if (msg_cnt_ff < msg_cap_ff) begin
                  tmpl_in.stored         = 1'b1;
                  tmpl_in.message_offset = msg_cnt_ff;
                  mc_next                = msg_cnt_ff + 16'd1;
               end
               msg_cnt_in = mc_next;
               if (pay_done) begin
                  tmpl_in.frame_end    = 1'b1;
                  tmpl_in.frame_length = pay_len_ff;
                  if (fin) begin
                     if (msg_cap_ff != 16'd0) begin
                        tmpl_in.message_end    = 1'b1;
                        tmpl_in.message_length = mc_next;
                     end
                     msg_cnt_in = 16'd0;
                  end
               end
            end else if (opc == wsfr_pkg::OPC_PING) begin
               cnt_in               = wsfr_pkg::BURST_CNT_W'(1);
               tmpl_in.kind         = wsfr_pkg::KIND_PONG;
               tmpl_in.frame_opcode = wsfr_pkg::OPC_PONG;
               bytes_in[0]          = rx_byte ^ key_byte;
            end
         end
         default: begin
         end
      endcase

      if (lc_err || fin_err2 || fin_err3) begin
         cnt_in       = wsfr_pkg::BURST_CNT_W'(1);
         tmpl_in.kind = wsfr_pkg::KIND_ERROR;
         if (lc_err) begin
            tmpl_in.error_code = wsfr_pkg::ERR_LEN_CODE;
         end else if (fin_err2) begin
            tmpl_in.error_code = wsfr_pkg::ERR_TOO_LARGE;
         end else begin
            tmpl_in.error_code = wsfr_pkg::ERR_PING_LONG;
         end
      end else if (hdr_ok) begin
         pay_cnt_in = 16'd0;
         if (opc == wsfr_pkg::OPC_PING) begin
            mask_in              = rx_mask;
            tmpl_in.kind         = wsfr_pkg::KIND_PONG;
            tmpl_in.frame_opcode = wsfr_pkg::OPC_PONG;
            bytes_in[0]          = {first_ff[7:4], wsfr_pkg::OPC_PONG};
            bytes_in[1]          = {1'b1, len_sel[6:0]};
            if (len_sel != 16'd0) begin
               cnt_in      = wsfr_pkg::BURST_CNT_W'(wsfr_pkg::BURST_MAX);
               bytes_in[2] = rx_mask[31:24];
               bytes_in[3] = rx_mask[23:16];
               bytes_in[4] = rx_mask[15:8];
               bytes_in[5] = rx_mask[7:0];
            end else begin
               cnt_in = wsfr_pkg::BURST_CNT_W'(2);
            end
         end else if ((opc <= wsfr_pkg::OPC_DATA_MAX) && (len_sel == 16'd0)) begin
            cnt_in            = wsfr_pkg::BURST_CNT_W'(1);
            tmpl_in.kind      = wsfr_pkg::KIND_EMPTY;
            tmpl_in.frame_end = 1'b1;
            if (fin) begin
               if (msg_cap_ff != 16'd0) begin
                  tmpl_in.message_end    = 1'b1;
                  tmpl_in.message_length = msg_cnt_ff;
               end
               msg_cnt_in = 16'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= wsfr_pkg::PH_HDR1;
         first_ff   <= 8'd0;
         ext_ff     <= 1'b0;
         pay_len_ff <= 16'd0;
         pay_cnt_ff <= 16'd0;
         msg_cnt_ff <= 16'd0;
         mask_ff    <= 32'd0;
         cnt_ff     <= '0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            first_ff   <= first_in;
            ext_ff     <= ext_in;
            pay_len_ff <= pay_len_in;
            pay_cnt_ff <= pay_cnt_in;
            msg_cnt_ff <= msg_cnt_in;
            mask_ff    <= mask_in;
            cnt_ff     <= cnt_in;
         end else if (pop) begin
            cnt_ff <= cnt_ff - wsfr_pkg::BURST_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_cap_ff  <= wsfr_pkg::RX_CAP_RESET;
         msg_cap_ff <= wsfr_pkg::MSG_CAP_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            wsfr_pkg::CSR_RX_CAPACITY:  rx_cap_ff  <= csr_wdata;
            wsfr_pkg::CSR_MSG_CAPACITY: msg_cap_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // result burst buffer, shifted down one byte per delivered item
   always_ff @(posedge clock) begin
      if (accept) begin
         tmpl_ff <= tmpl_in;
         for (int i = 0; i < wsfr_pkg::BURST_MAX; i++) begin
            bytes_ff[i] <= bytes_in[i];
         end
      end else if (pop) begin
         for (int i = 0; i < wsfr_pkg::BURST_MAX - 1; i++) begin
            bytes_ff[i] <= bytes_ff[i+1];
         end
         bytes_ff[wsfr_pkg::BURST_MAX-1] <= 8'd0;
      end
   end

   assign rsp_tuser = tmpl_ff.kind;
   assign rsp_tlast = (cnt_ff == wsfr_pkg::BURST_CNT_W'(1));
   assign rsp_tdata = {7'd0,
                       tmpl_ff.error_code,
                       tmpl_ff.message_length,
                       tmpl_ff.message_end,
                       tmpl_ff.frame_length,
                       tmpl_ff.frame_end,
                       tmpl_ff.frame_opcode,
                       tmpl_ff.message_offset,
                       tmpl_ff.stored,
                       bytes_ff[0]};

endmodule
